FILE: hdl/ddsfb_pkg.sv
`default_nettype none
package ddsfb_pkg;

  // Register port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PULSES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAXENC = 2'd2;

  localparam logic [23:0] PULSES_RST = 24'd256;
  localparam logic [15:0] TRACK_RST  = 16'd4096;
  localparam logic [14:0] MAXENC_RST = 15'd32767;

  // Frame bytes
  localparam logic [7:0] SYNC0     = 8'h55;
  localparam logic [7:0] SYNC1     = 8'hAA;
  localparam logic [7:0] LEN_SPEED = 8'h09;
  localparam logic [7:0] LEN_RESET = 8'h02;
  localparam logic [7:0] OP_SPEED  = 8'h01;
  localparam logic [7:0] OP_RESET  = 8'h05;

  // Position of the checksum byte in each frame kind
  localparam logic [3:0] SPEED_XOR_IDX = 4'd13;
  localparam logic [3:0] RESET_XOR_IDX = 4'd7;

  // Datapath widths
  localparam int unsigned MAG_W  = 56;  // |(V*8192 -/+ T*W) * P|
  localparam int unsigned ACC_W  = 58;  // division remainder, up to 3x divisor
  localparam int unsigned FRAC_W = 29;  // binary point of the wheel product
  localparam int unsigned QUO_W  = 15;  // quotient bits, as wide as max_encoding

  typedef struct packed {
    logic               command;
    logic signed [15:0] lin_vel;
    logic signed [15:0] ang_vel;
  } ddsfb_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } ddsfb_out_t;

  typedef struct packed {
    logic        is_reset;
    logic [7:0]  seq;
    logic [15:0] left;
    logic [15:0] right;
  } ddsfb_frame_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TWMUL,
    S_LSUM,
    S_LMUL,
    S_RSUM,
    S_RMUL,
    S_MAX,
    S_CMP,
    S_DIV_ADD,
    S_DIV_SUB,
    S_EMIT
  } ddsfb_state_e;

endpackage
`default_nettype wire

FILE: hdl/ddsfb_frame_tx.sv
`default_nettype none
module ddsfb_frame_tx (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  ddsfb_pkg::ddsfb_frame_t frame_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ddsfb_pkg::ddsfb_out_t out_data_o
);
  import ddsfb_pkg::*;

  logic         busy_q;
  ddsfb_frame_t frame_q;
  logic [3:0]   idx_q;
  logic [7:0]   xor_q;
  logic         out_valid_q;
  ddsfb_out_t   out_q;

  logic       load;
  logic       at_last;
  logic [7:0] data_byte;
  logic [7:0] next_byte;

  assign load    = busy_q && (!out_valid_q || !out_stall_i);
  assign at_last = idx_q == (frame_q.is_reset ? RESET_XOR_IDX : SPEED_XOR_IDX);

  always_comb begin
    case (idx_q)
      4'd0: data_byte = SYNC0;
      4'd1: data_byte = SYNC1;
      4'd2: data_byte = frame_q.is_reset ? LEN_RESET : LEN_SPEED;
      4'd3: data_byte = frame_q.seq;
      4'd4: data_byte = frame_q.is_reset ? OP_RESET : OP_SPEED;
      4'd5: data_byte = frame_q.is_reset ? 8'h00 : frame_q.left[15:8];
      4'd6: data_byte = frame_q.is_reset ? 8'h00 : frame_q.left[7:0];
      4'd7: data_byte = frame_q.right[15:8];
      4'd8: data_byte = frame_q.right[7:0];
      default: data_byte = 8'h00;
    endcase
  end

  assign next_byte = at_last ? xor_q : data_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (load && at_last) begin
        busy_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      frame_q <= frame_i;
      idx_q   <= '0;
      xor_q   <= '0;
    end else if (load) begin
      out_q.frame_byte <= next_byte;
      out_q.last       <= at_last;
      xor_q            <= xor_q ^ data_byte;
      idx_q            <= idx_q + 4'd1;
    end
  end

  assign ready_o     = !busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

FILE: hdl/diff_drive_speed_frame_builder_unit.sv
`default_nettype none
// Differential-drive speed frame builder. A speed command (left/right wheel pulse rates from
// linear and angular speed, scaled down proportionally when either exceeds max_encoding)
// passes through one shared 32x24 multiplier and one shared 58-bit add/subtract unit,
// plus, only when scaling is needed, a shift-and-subtract division per wheel of 15 quotient
// steps; a reset command goes straight to the handoff. The 14-byte (speed) or 8-byte (reset)
// frame then leaves at one byte per cycle while out_stall_i is low, from an output
// register, overlapping the arithmetic of the next command. in_stall_o is high from accept
// until the frame is handed to the byte serializer, and the handoff also waits for the
// previous frame's bytes to be loaded.
module diff_drive_speed_frame_builder_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ddsfb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ddsfb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  ddsfb_pkg::ddsfb_in_t                 in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output ddsfb_pkg::ddsfb_out_t                out_data_o
);
  import ddsfb_pkg::*;

  // Configuration
  logic [23:0] ppm_q;
  logic [15:0] trk_q;
  logic [14:0] me_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppm_q <= PULSES_RST;
      trk_q <= TRACK_RST;
      me_q  <= MAXENC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PULSES: ppm_q <= cfg_data_i;
        REG_TRACK:  trk_q <= cfg_data_i[15:0];
        REG_MAXENC: me_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  ddsfb_state_e state_q, state_d;
  logic [7:0]   seq_q;
  logic [7:0]   fseq_q;
  logic         cmd_q;
  logic [15:0]  v_q;
  logic [15:0]  w_q;
  logic [30:0]  twm_q;
  logic [32:0]  sum_q;
  logic [MAG_W-1:0] lmag_q, rmag_q, dmax_q;
  logic         lneg_q, rneg_q;
  logic [ACC_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [3:0]   bit_q;
  logic         side_q;
  logic [15:0]  left_q, right_q;

  logic accept;
  logic tx_ready;
  logic tx_start;
  ddsfb_frame_t tx_frame;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;
  assign tx_start   = (state_q == S_EMIT) && tx_ready;

  // Shared multiplier
  logic [15:0]      w_mag;
  logic [32:0]      sum_abs;
  logic [31:0]      mul_a;
  logic [23:0]      mul_b;
  logic [MAG_W-1:0] prod;

  assign w_mag   = w_q[15] ? 16'(-w_q) : w_q;
  assign sum_abs = sum_q[32] ? 33'(-sum_q) : sum_q;

  always_comb begin
    case (state_q)
      S_TWMUL: begin
        mul_a = {16'b0, w_mag};
        mul_b = {8'b0, trk_q};
      end
      default: begin
        mul_a = sum_abs[31:0];
        mul_b = ppm_q;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Shared add/subtract unit; carry out high on subtract means a >= b
  logic [ACC_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_sub, alu_co;
  logic [ACC_W-1:0] s_ext;
  logic [MAG_W-1:0] cur_mag;
  logic             cur_neg;

  assign s_ext   = {{(ACC_W-29){v_q[15]}}, v_q, 13'b0};
  assign cur_mag = side_q ? rmag_q : lmag_q;
  assign cur_neg = side_q ? rneg_q : lneg_q;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state_q)
      S_LSUM: begin
        alu_a   = s_ext;
        alu_b   = {{(ACC_W-31){1'b0}}, twm_q};
        alu_sub = !w_q[15];
      end
      S_RSUM: begin
        alu_a   = s_ext;
        alu_b   = {{(ACC_W-31){1'b0}}, twm_q};
        alu_sub = w_q[15];
      end
      S_MAX: begin
        alu_a = {2'b0, lmag_q};
        alu_b = {2'b0, rmag_q};
      end
      S_CMP: begin
        alu_a = {{(ACC_W-QUO_W-FRAC_W){1'b0}}, me_q, {FRAC_W{1'b0}}};
        alu_b = {2'b0, dmax_q};
      end
      S_DIV_ADD: begin
        alu_a   = {rem_q[ACC_W-2:0], 1'b0};
        alu_b   = me_q[bit_q] ? {2'b0, cur_mag} : '0;
        alu_sub = 1'b0;
      end
      S_DIV_SUB: begin
        alu_a = rem_q;
        alu_b = {2'b0, dmax_q};
      end
      default: ;
    endcase
  end

  assign {alu_co, alu_res} = {1'b0, alu_a} + {1'b0, alu_sub ? ~alu_b : alu_b}
                             + (ACC_W+1)'(alu_sub);

  // Unscaled wheels and finished quotient
  logic [15:0] lq16, rq16, qval;
  assign lq16 = lmag_q[FRAC_W+15:FRAC_W];
  assign rq16 = rmag_q[FRAC_W+15:FRAC_W];
  assign qval = cur_neg ? 16'(-{1'b0, quo_q}) : {1'b0, quo_q};

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      seq_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        seq_q <= seq_q + 8'd1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (accept) begin
        state_d = in_data_i.command ? S_EMIT : S_TWMUL;
      end
      S_TWMUL:   state_d = S_LSUM;
      S_LSUM:    state_d = S_LMUL;
      S_LMUL:    state_d = S_RSUM;
      S_RSUM:    state_d = S_RMUL;
      S_RMUL:    state_d = S_MAX;
      S_MAX:     state_d = S_CMP;
      S_CMP:     state_d = alu_co ? S_EMIT : S_DIV_ADD;
      S_DIV_ADD: state_d = S_DIV_SUB;
      S_DIV_SUB: begin
        if (alu_co) begin
          state_d = S_DIV_SUB;
        end else if (bit_q == 4'd0) begin
          state_d = side_q ? S_EMIT : S_DIV_ADD;
        end else begin
          state_d = S_DIV_ADD;
        end
      end
      S_EMIT:    if (tx_ready) begin
        state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (accept) begin
        cmd_q  <= in_data_i.command;
        v_q    <= in_data_i.lin_vel;
        w_q    <= in_data_i.ang_vel;
        fseq_q <= seq_q;
      end
      S_TWMUL: twm_q <= prod[30:0];
      S_LSUM:  sum_q <= alu_res[32:0];
      S_LMUL: begin
        lmag_q <= prod;
        lneg_q <= sum_q[32];
      end
      S_RSUM:  sum_q <= alu_res[32:0];
      S_RMUL: begin
        rmag_q <= prod;
        rneg_q <= sum_q[32];
      end
      S_MAX:   dmax_q <= alu_co ? lmag_q : rmag_q;
      S_CMP: begin
        if (alu_co) begin
          left_q  <= lneg_q ? 16'(-lq16) : lq16;
          right_q <= rneg_q ? 16'(-rq16) : rq16;
        end else begin
          rem_q  <= '0;
          quo_q  <= '0;
          bit_q  <= 4'(QUO_W - 1);
          side_q <= 1'b0;
        end
      end
      S_DIV_ADD: begin
        rem_q <= alu_res;
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
      S_DIV_SUB: begin
        if (alu_co) begin
          // remainder still at or above the divisor: take one more out
          rem_q <= alu_res;
          quo_q <= quo_q + QUO_W'(1);
        end else if (bit_q == 4'd0) begin
          if (side_q) begin
            right_q <= qval;
          end else begin
            left_q <= qval;
          end
          side_q <= 1'b1;
          rem_q  <= '0;
          quo_q  <= '0;
          bit_q  <= 4'(QUO_W - 1);
        end else begin
          bit_q <= bit_q - 4'd1;
        end
      end
      default: ;
    endcase
  end

  assign tx_frame.is_reset = cmd_q;
  assign tx_frame.seq      = fseq_q;
  assign tx_frame.left     = left_q;
  assign tx_frame.right    = right_q;

  ddsfb_frame_tx u_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (tx_start),
    .frame_i     (tx_frame),
    .ready_o     (tx_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  function automatic logic [15:0] mag16(input logic [15:0] x);
    return x[15] ? 16'(-x) : x;
  endfunction

  a_seq_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> seq_q == $past(seq_q) + 8'd1)
    else $error("sequence number did not advance on command transfer");

  a_quo_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV_ADD || state_q == S_DIV_SUB) |-> quo_q <= me_q)
    else $error("partial quotient above max_encoding");

  a_wheel_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !cmd_q) |->
      (mag16(left_q) <= {1'b0, me_q} && mag16(right_q) <= {1'b0, me_q}))
    else $error("wheel value exceeds max_encoding");

endmodule
`default_nettype wire
